### hw/rtl/pixel_color_adjust_defines.svh
// assertion macros shared by the pixel color adjust block
// the enclosing module provides clk_i and rst_ni
`ifndef PIXEL_COLOR_ADJUST_DEFINES_SVH
`define PIXEL_COLOR_ADJUST_DEFINES_SVH

// same-cycle implication
`define PCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pca_pkg.sv
package pca_pkg;

  localparam int unsigned NumStages = 7;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;

  // rec.601 luma weights in 1/65536, summing to 65536
  localparam logic [16:0] LumaW [NumChan] = '{17'd19595, 17'd38470, 17'd7471};

  localparam logic [9:0] GainUnity = 10'd256;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BRIGHT   = 3'd0,
    REG_CONTRAST = 3'd1,
    REG_SAT      = 3'd2,
    REG_TEMP     = 3'd3,
    REG_TINT     = 3'd4
  } pca_reg_e;

  typedef struct packed {
    logic [12:0] bright;
    logic [9:0]  contrast;
    logic [9:0]  saturation;
    logic [12:0] temp;
    logic [12:0] tint;
  } pca_cfg_t;

  // rgb[0] red, rgb[1] green, rgb[2] blue
  typedef struct packed {
    logic [NumChan-1:0][7:0] rgb;
    logic [7:0]              alpha;
  } pca_pix_t;

endpackage

### hw/rtl/pca_in_if.sv
interface pca_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

### hw/rtl/pca_out_if.sv
interface pca_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

### hw/rtl/pixel_color_adjust.sv
// pixel color adjust: brightness, contrast, temperature / tint and saturation
// on an rgba pixel stream.
// pix_i takes one pixel per word, pix_o gives one adjusted pixel per word,
// in order; alpha passes through, and a pixel with alpha zero passes as is.
// throughput is one pixel per clock while pix_o is ready, set by the
// seven register stages (brightness, contrast, luma weights, luma sum,
// luma distance, saturation gain, clamp) that each hold one pixel.
// when pix_o stalls, the full stages hold their words and empty stages keep
// filling; pix_i.ready drops only once every stage holds a word.
// the cfg port writes one register per cycle at cfg_idx_i (0 brightness,
// 1 contrast, 2 saturation, 3 temperature, 4 tint); other indexes are
// ignored; write only while no pixel is in flight.
// reset empties the pipeline and returns all registers to neutral (offsets
// 0, gains 256 = unity).
`include "pixel_color_adjust_defines.svh"

module pixel_color_adjust import pca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  pca_in_if.sink              pix_i,
  pca_out_if.source           pix_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  pca_cfg_t cfg_q;
  pca_pix_t in_pix;
  pca_pix_t out_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright     <= '0;
      cfg_q.contrast   <= GainUnity;
      cfg_q.saturation <= GainUnity;
      cfg_q.temp       <= '0;
      cfg_q.tint       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BRIGHT:   cfg_q.bright     <= cfg_data_i;
        REG_CONTRAST: cfg_q.contrast   <= cfg_data_i[9:0];
        REG_SAT:      cfg_q.saturation <= cfg_data_i[9:0];
        REG_TEMP:     cfg_q.temp       <= cfg_data_i;
        REG_TINT:     cfg_q.tint       <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign in_pix.rgb[0] = pix_i.red_in;
  assign in_pix.rgb[1] = pix_i.green_in;
  assign in_pix.rgb[2] = pix_i.blue_in;
  assign in_pix.alpha  = pix_i.alpha_in;

  pca_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .in_pix_i    (in_pix),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .out_pix_o   (out_pix)
  );

  assign pix_o.red_out   = out_pix.rgb[0];
  assign pix_o.green_out = out_pix.rgb[1];
  assign pix_o.blue_out  = out_pix.rgb[2];
  assign pix_o.alpha_out = out_pix.alpha;

  // an empty output stage lets the whole pipeline advance
  `PCA_ASSERT_IMP(a_ready_when_out_empty, !pix_o.valid, pix_i.ready, "input stalled with empty output")
  `PCA_ASSERT_NXT(a_contrast_write, cfg_we_i && (cfg_idx_i == REG_CONTRAST), cfg_q.contrast == $past(cfg_data_i[9:0]), "contrast write lost")
  `PCA_ASSERT_NXT(a_bright_write, cfg_we_i && (cfg_idx_i == REG_BRIGHT), cfg_q.bright == $past(cfg_data_i), "brightness write lost")

endmodule

### hw/rtl/pca_core.sv
module pca_core import pca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pca_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pca_pix_t in_pix_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pca_pix_t out_pix_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  // stage 0: brightness, centered on 128
  logic signed [13:0] d_d    [NumChan];
  logic signed [13:0] d_q    [NumChan];
  // stage 1: contrast plus temperature / tint, q12
  logic signed [13:0] off    [NumChan];
  logic signed [24:0] prod   [NumChan];
  logic signed [24:0] sum    [NumChan];
  logic signed [23:0] v12_d  [NumChan];
  logic signed [23:0] v12_q  [NumChan];
  // stage 2: weighted channels
  logic signed [39:0] wp_d   [NumChan];
  logic signed [39:0] wp_q   [NumChan];
  logic signed [23:0] v12b_q [NumChan];
  // stage 3: luma, q28
  logic signed [39:0] luma_d;
  logic signed [39:0] luma_q;
  logic signed [23:0] v12c_q [NumChan];
  // stage 4: distance from luma
  logic signed [40:0] t_d    [NumChan];
  logic signed [40:0] t_q    [NumChan];
  logic signed [39:0] luma4_q;
  // stage 5: saturation gain
  logic signed [51:0] m_d    [NumChan];
  logic signed [51:0] m_q    [NumChan];
  logic signed [39:0] luma5_q;
  // stage 6: q36 result, clamp
  logic signed [51:0] y      [NumChan];
  pca_pix_t           res_d;
  pca_pix_t           res_q;

  pca_pix_t pix_q [NumStages-1];

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_pix_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_comb begin
    off[0] = {cfg_i.temp[12], cfg_i.temp};
    off[1] = {cfg_i.tint[12], cfg_i.tint};
    off[2] = 14'sd0 - $signed({cfg_i.temp[12], cfg_i.temp});
    for (int c = 0; c < NumChan; c++) begin
      d_d[c]   = $signed({2'b00, in_pix_i.rgb[c], 4'b0000})
               + $signed({cfg_i.bright[12], cfg_i.bright}) - 14'sd2048;
      prod[c]  = 25'(d_q[c]) * 25'($signed({1'b0, cfg_i.contrast}));
      sum[c]   = prod[c] + 25'sd524288 + $signed({{3{off[c][13]}}, off[c], 8'h00});
      v12_d[c] = sum[c][23:0];
      wp_d[c]  = 40'(v12_q[c]) * 40'($signed({1'b0, LumaW[c]}));
      t_d[c]   = $signed({v12c_q[c][23], v12c_q[c], 16'h0000})
               - $signed({luma_q[39], luma_q});
      m_d[c]   = 52'(t_q[c]) * 52'($signed({1'b0, cfg_i.saturation}));
      y[c]     = m_q[c] + $signed({{4{luma5_q[39]}}, luma5_q, 8'h00});
    end
    luma_d = wp_q[0] + wp_q[1] + wp_q[2];

    res_d.alpha = pix_q[NumStages-2].alpha;
    for (int c = 0; c < NumChan; c++) begin
      if (pix_q[NumStages-2].alpha == 8'd0) begin
        res_d.rgb[c] = pix_q[NumStages-2].rgb[c];
      end else if (y[c][51]) begin
        res_d.rgb[c] = 8'd0;
      end else if (|y[c][50:44]) begin
        res_d.rgb[c] = 8'd255;
      end else begin
        res_d.rgb[c] = y[c][43:36];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d_q      <= d_d;
      pix_q[0] <= in_pix_i;
    end
    if (en[1]) begin
      v12_q    <= v12_d;
      pix_q[1] <= pix_q[0];
    end
    if (en[2]) begin
      wp_q     <= wp_d;
      v12b_q   <= v12_q;
      pix_q[2] <= pix_q[1];
    end
    if (en[3]) begin
      luma_q   <= luma_d;
      v12c_q   <= v12b_q;
      pix_q[3] <= pix_q[2];
    end
    if (en[4]) begin
      t_q      <= t_d;
      luma4_q  <= luma_q;
      pix_q[4] <= pix_q[3];
    end
    if (en[5]) begin
      m_q      <= m_d;
      luma5_q  <= luma4_q;
      pix_q[5] <= pix_q[4];
    end
    if (en[6]) begin
      res_q    <= res_d;
    end
  end

endmodule
